// ===== hdl/tao_pkg.sv =====
package tao_pkg;

	localparam int DATA_W = 16;
	localparam int WINDOW_DEF = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	localparam logic signed [DATA_W-1:0] OFFSET_X_RST = -16'sd29;
	localparam logic signed [DATA_W-1:0] OFFSET_Y_RST = -16'sd16;
	localparam logic signed [DATA_W-1:0] OFFSET_Z_RST = -16'sd15;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} tao_sample_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} tao_pipe_ctl_t;

endpackage

// ===== hdl/tao_cell.sv =====
module tao_cell
	import tao_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift_en,
	input  tao_sample_t d,
	output tao_sample_t q
);

	tao_sample_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// ===== hdl/tao_div.sv =====
module tao_div
	import tao_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  tao_pipe_ctl_t                               ctl,
	input  logic signed [DATA_W+$clog2(WINDOW)-1:0]     sum,
	output logic signed [DATA_W-1:0]                    quot
);

	localparam int SUM_W = DATA_W + $clog2(WINDOW);
	localparam int MAG_W = SUM_W;
	localparam int SHIFT = MAG_W + $clog2(WINDOW);
	localparam int MUL_W = MAG_W + 1;
	localparam int PROD_W = MAG_W + MUL_W;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [MUL_W-1:0] RECIP = RECIP_WIDE[MUL_W-1:0];

	logic              neg_s2;
	logic [MAG_W-1:0]  mag_s2;
	logic              neg_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              neg;
	logic [MAG_W-1:0]  mag;
	logic [DATA_W-1:0] q_abs;

	// The mean truncates toward zero, so the magnitude is divided and the sign restored.
	always_comb begin
		neg = sum[SUM_W-1];
		mag = neg ? MAG_W'(-sum) : MAG_W'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_s2 <= 1'b0;
			neg_s3 <= 1'b0;
		end else begin
			if (ctl.ld_s2) begin
				neg_s2 <= neg;
			end
			if (ctl.ld_s3) begin
				neg_s3 <= neg_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			mag_s2 <= mag;
		end
		if (ctl.ld_s3) begin
			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(RECIP);
		end
	end

	assign q_abs = prod_s3[SHIFT +: DATA_W];
	assign quot = neg_s3 ? -$signed(q_abs) : $signed(q_abs);

endmodule

// ===== hdl/three_axis_offset_moving_average_core.sv =====
// Offset-corrected moving average of a three-axis gyro sample stream. Each request
// carries one raw word per axis; the block subtracts that axis's offset register,
// wraps the difference to signed 16 bits, and returns the mean over the last WINDOW
// corrected samples, truncated toward zero, with zeros standing in for samples not
// yet seen after reset. One request is taken every clock cycle unless out_ready is
// low with output held; it passes the sum, divider and output registers. The rate is
// set by the running sum per axis, which adds the new sample and drops the oldest one
// from a shift chain of WINDOW cells; division is a two-stage reciprocal multiply.
module three_axis_offset_moving_average_core
	import tao_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DATA_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [DATA_W-1:0]           raw_x,
	input  logic [DATA_W-1:0]           raw_y,
	input  logic [DATA_W-1:0]           raw_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [DATA_W-1:0]    mean_x,
	output logic signed [DATA_W-1:0]    mean_y,
	output logic signed [DATA_W-1:0]    mean_z
);

	localparam int SUM_W = DATA_W + $clog2(WINDOW);

	logic signed [DATA_W-1:0] offset_x_q;
	logic signed [DATA_W-1:0] offset_y_q;
	logic signed [DATA_W-1:0] offset_z_q;

	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic signed [SUM_W-1:0] sum_z_q;

	logic signed [DATA_W-1:0] mean_x_q;
	logic signed [DATA_W-1:0] mean_y_q;
	logic signed [DATA_W-1:0] mean_z_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	logic rdy_out;
	logic rdy_s3;
	logic rdy_s2;
	logic accept;

	tao_pipe_ctl_t ctl;
	tao_sample_t   corr;
	tao_sample_t   oldest;
	tao_sample_t   chain [WINDOW+1];

	logic signed [DATA_W-1:0] quot_x;
	logic signed [DATA_W-1:0] quot_y;
	logic signed [DATA_W-1:0] quot_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= OFFSET_X_RST;
			offset_y_q <= OFFSET_Y_RST;
			offset_z_q <= OFFSET_Z_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_OFFSET_X: offset_x_q <= $signed(cfg_data);
				REG_OFFSET_Y: offset_y_q <= $signed(cfg_data);
				REG_OFFSET_Z: offset_z_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s3   = !valid_s3 || rdy_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign in_ready = !valid_s1 || rdy_s2;
	assign accept   = in_valid && in_ready;

	assign ctl.ld_s2 = valid_s1 && rdy_s2;
	assign ctl.ld_s3 = valid_s2 && rdy_s3;

	always_comb begin
		corr.x = $signed(raw_x - offset_x_q);
		corr.y = $signed(raw_y - offset_y_q);
		corr.z = $signed(raw_z - offset_z_q);
	end

	assign chain[0] = corr;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		tao_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.d        (chain[i]),
			.q        (chain[i+1])
		);
	end

	assign oldest = chain[WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (accept) begin
			sum_x_q <= sum_x_q + SUM_W'(corr.x) - SUM_W'(oldest.x);
			sum_y_q <= sum_y_q + SUM_W'(corr.y) - SUM_W'(oldest.y);
			sum_z_q <= sum_z_q + SUM_W'(corr.z) - SUM_W'(oldest.z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	tao_div #(.WINDOW(WINDOW)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sum    (sum_x_q),
		.quot   (quot_x)
	);

	tao_div #(.WINDOW(WINDOW)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sum    (sum_y_q),
		.quot   (quot_y)
	);

	tao_div #(.WINDOW(WINDOW)) u_div_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sum    (sum_z_q),
		.quot   (quot_z)
	);

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			mean_x_q <= quot_x;
			mean_y_q <= quot_y;
			mean_z_q <= quot_z;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_x    = mean_x_q;
	assign mean_y    = mean_y_q;
	assign mean_z    = mean_z_q;

endmodule
